/* src/cpu8alu_pkg.sv */
// Package with the operation codes, flag positions and transaction types of the 8-bit ALU.
package cpu8alu_pkg;

  // Operation codes. Codes 22 to 31 are unused.
  typedef enum logic [4:0] {
    FN_ADD   = 5'd0,
    FN_ADC   = 5'd1,
    FN_SUB   = 5'd2,
    FN_SBC   = 5'd3,
    FN_CP    = 5'd4,
    FN_DAA   = 5'd5,
    FN_RLCA  = 5'd6,
    FN_RLA   = 5'd7,
    FN_RRCA  = 5'd8,
    FN_RRA   = 5'd9,
    FN_RLC   = 5'd10,
    FN_RRC   = 5'd11,
    FN_RL    = 5'd12,
    FN_RR    = 5'd13,
    FN_SLA   = 5'd14,
    FN_SRA   = 5'd15,
    FN_SWAP  = 5'd16,
    FN_SRL   = 5'd17,
    FN_BIT   = 5'd18,
    FN_RES   = 5'd19,
    FN_SET   = 5'd20,
    FN_ADD16 = 5'd21
  } func_t;

  // Flag bit positions.
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  // Decimal adjust constants.
  localparam logic [7:0] DAA_LIMIT = 8'h99;
  localparam logic [7:0] DAA_HI    = 8'h60;
  localparam logic [7:0] DAA_LO    = 8'h06;
  localparam logic [3:0] DAA_DIGIT = 4'd9;

  typedef struct packed {
    logic [4:0]  func;
    logic [7:0]  acc;
    logic [7:0]  operand;
    logic [2:0]  bit_index;
    logic [3:0]  flags;
    logic [15:0] pair_value;
    logic [15:0] wide_operand;
  } alu_op_t;

  typedef struct packed {
    logic [15:0] result;
    logic [3:0]  flags;
    logic        writes_result;
  } alu_res_t;

endpackage

/* src/cpu8alu_core.sv */
// Combinational datapath of the 8-bit ALU: arithmetic, rotates, bit group and pair add.
module cpu8alu_core import cpu8alu_pkg::*; (
  input  alu_op_t  op,
  output alu_res_t res
);

  logic       cin;
  logic       use_c;
  logic [8:0] sum9;
  logic [4:0] sum_lo;
  logic [8:0] dif9;
  logic [4:0] dif_lo;
  logic [16:0] sum17;
  logic [12:0] sum13;
  logic       daa_lo;
  logic       daa_hi;
  logic [7:0] daa_corr;
  logic [7:0] daa_val;
  logic [7:0] v;
  logic [7:0] a;
  logic [7:0] r8;
  logic       sh_c;
  logic       tbit;

  assign a   = op.acc;
  assign v   = op.operand;
  assign cin = op.flags[FLAG_C];
  assign use_c = (op.func == FN_ADC) || (op.func == FN_SBC);

  assign sum9   = {1'b0, a} + {1'b0, v} + {8'd0, use_c & cin};
  assign sum_lo = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, use_c & cin};
  assign dif9   = {1'b0, a} - {1'b0, v} - {8'd0, use_c & cin};
  assign dif_lo = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, use_c & cin};

  assign sum17 = {1'b0, op.pair_value} + {1'b0, op.wide_operand};
  assign sum13 = {1'b0, op.pair_value[11:0]} + {1'b0, op.wide_operand[11:0]};

  // Decimal adjust: the correction is subtracted after a subtraction, else added.
  assign daa_lo   = op.flags[FLAG_H] || (!op.flags[FLAG_N] && (a[3:0] > DAA_DIGIT));
  assign daa_hi   = op.flags[FLAG_C] || (!op.flags[FLAG_N] && (a > DAA_LIMIT));
  assign daa_corr = (daa_lo ? DAA_LO : 8'h00) | (daa_hi ? DAA_HI : 8'h00);
  assign daa_val  = op.flags[FLAG_N] ? (a - daa_corr) : (a + daa_corr);

  assign tbit = v[op.bit_index];

  always_comb begin
    res.result        = 16'd0;
    res.flags         = op.flags;
    res.writes_result = 1'b1;
    r8                = 8'd0;
    sh_c              = 1'b0;
    unique case (op.func)
      FN_ADD, FN_ADC: begin
        res.result = {8'd0, sum9[7:0]};
        res.flags  = {sum9[7:0] == 8'd0, 1'b0, sum_lo[4], sum9[8]};
      end
      FN_SUB, FN_SBC: begin
        res.result = {8'd0, dif9[7:0]};
        res.flags  = {dif9[7:0] == 8'd0, 1'b1, dif_lo[4], dif9[8]};
      end
      FN_CP: begin
        res.flags         = {dif9[7:0] == 8'd0, 1'b1, dif_lo[4], dif9[8]};
        res.writes_result = 1'b0;
      end
      FN_DAA: begin
        res.result = {8'd0, daa_val};
        res.flags  = {daa_val == 8'd0, op.flags[FLAG_N], 1'b0, daa_hi};
      end
      FN_RLCA: begin
        res.result = {8'd0, a[6:0], a[7]};
        res.flags  = {3'b000, a[7]};
      end
      FN_RLA: begin
        res.result = {8'd0, a[6:0], cin};
        res.flags  = {3'b000, a[7]};
      end
      FN_RRCA: begin
        res.result = {8'd0, a[0], a[7:1]};
        res.flags  = {3'b000, a[0]};
      end
      FN_RRA: begin
        res.result = {8'd0, cin, a[7:1]};
        res.flags  = {3'b000, a[0]};
      end
      FN_RLC, FN_RRC, FN_RL, FN_RR, FN_SLA, FN_SRA, FN_SRL: begin
        unique case (op.func)
          FN_RLC:  begin r8 = {v[6:0], v[7]}; sh_c = v[7]; end
          FN_RRC:  begin r8 = {v[0], v[7:1]}; sh_c = v[0]; end
          FN_RL:   begin r8 = {v[6:0], cin};  sh_c = v[7]; end
          FN_RR:   begin r8 = {cin, v[7:1]};  sh_c = v[0]; end
          FN_SLA:  begin r8 = {v[6:0], 1'b0}; sh_c = v[7]; end
          FN_SRA:  begin r8 = {v[7], v[7:1]}; sh_c = v[0]; end
          default: begin r8 = {1'b0, v[7:1]}; sh_c = v[0]; end
        endcase
        res.result = {8'd0, r8};
        res.flags  = {r8 == 8'd0, 2'b00, sh_c};
      end
      FN_SWAP: begin
        res.result = {8'd0, v[3:0], v[7:4]};
        res.flags  = {v == 8'd0, 3'b000};
      end
      FN_BIT: begin
        res.flags         = {~tbit, 1'b0, 1'b1, cin};
        res.writes_result = 1'b0;
      end
      FN_RES: res.result = {8'd0, v & ~(8'd1 << op.bit_index)};
      FN_SET: res.result = {8'd0, v | (8'd1 << op.bit_index)};
      FN_ADD16: begin
        res.result = sum17[15:0];
        res.flags  = {op.flags[FLAG_Z], 1'b0, sum13[12], sum17[16]};
      end
      default: res.writes_result = 1'b0;
    endcase
  end

endmodule

/* src/cpu8alu_with_bit_ops.sv */
// Top level of the 8-bit ALU: input register, datapath and result register.
// This ALU takes one operation per clock cycle and is never busy: busy is tied low,
// so every cycle with start high starts a transaction. Each transaction is captured
// in an input register, passes through one level of combinational datapath (8-bit
// add and subtract, decimal adjust, rotates and shifts, swap, bit test/reset/set and
// a 16-bit pair add) and lands in a result register. The result appears on the out_
// ports with out_valid high for exactly one cycle, once the transaction has passed
// the two register stages (the input register, then the result register); the
// receiver cannot stall it.
// Results come out in the order the transactions went in. For compare, bit test and
// unused operation codes out_writes_result is low and out_result is zero; flags that
// an operation does not define pass through from in_flags_in unchanged.
module cpu8_alu_with_bit_ops import cpu8alu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [4:0]  in_func,
  input  logic [7:0]  in_acc,
  input  logic [7:0]  in_operand,
  input  logic [2:0]  in_bit_index,
  input  logic [3:0]  in_flags_in,
  input  logic [15:0] in_pair_value,
  input  logic [15:0] in_wide_operand,
  output logic        out_valid,
  output logic [15:0] out_result,
  output logic [3:0]  out_flags_out,
  output logic        out_writes_result
);

  alu_op_t  op_r;
  logic     op_valid_r;
  alu_res_t res_nxt;
  alu_res_t res_r;
  logic     res_valid_r;

  // The pipeline advances every cycle, so the block can always take a transaction.
  assign busy = 1'b0;

  // Input register: control bit is reset, payload is not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_valid_r <= 1'b0;
    end else begin
      op_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= '{func:         in_func,
              acc:          in_acc,
              operand:      in_operand,
              bit_index:    in_bit_index,
              flags:        in_flags_in,
              pair_value:   in_pair_value,
              wide_operand: in_wide_operand};
  end

  cpu8alu_core u_core (
    .op  (op_r),
    .res (res_nxt)
  );

  // Result register: the strobe is the input register's strobe, registered once more.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else begin
      res_valid_r <= op_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid         = res_valid_r;
  assign out_result        = res_r.result;
  assign out_flags_out     = res_r.flags;
  assign out_writes_result = res_r.writes_result;

  // Every accepted transaction yields exactly one result after the input and result registers.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("accepted transaction produced no result");

  // No result appears without a transaction in the input register the cycle before.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(res_valid_r) |-> $past(op_valid_r))
    else $error("result strobe without a transaction");

  // Operations that write nothing back deliver a zero result.
  a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_writes_result) |-> (out_result == 16'd0))
    else $error("non-writing operation returned a nonzero result");

endmodule

/* tb/alu_checker.sv */
// Checker for the 8-bit ALU: watches both channels, predicts each result and compares.
module alu_checker import cpu8alu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [4:0]  in_func,
  input  logic [7:0]  in_acc,
  input  logic [7:0]  in_operand,
  input  logic [2:0]  in_bit_index,
  input  logic [3:0]  in_flags_in,
  input  logic [15:0] in_pair_value,
  input  logic [15:0] in_wide_operand,
  input  logic        out_valid,
  input  logic [15:0] out_result,
  input  logic [3:0]  out_flags_out,
  input  logic        out_writes_result,
  output int unsigned fail_count,
  output int unsigned pending
);

  alu_res_t results_due[$];

  function automatic alu_res_t alu_predict(input alu_op_t op);
    logic [7:0]  a;
    logic [7:0]  v;
    logic [3:0]  f;
    logic        cin;
    logic        c;
    logic [8:0]  sum9;
    logic [4:0]  nib;
    logic [16:0] sum17;
    logic [12:0] low13;
    logic [7:0]  r8;
    logic [7:0]  corr;
    logic        dec_sub;
    logic        dec_c;
    logic [3:0]  nf;
    logic        wr;
    logic        wide;
    alu_res_t    res;
    a = op.acc;
    v = op.operand;
    f = op.flags;
    cin = f[FLAG_C];
    r8 = 8'h00;
    nf = f;
    wr = 1'b1;
    wide = 1'b0;
    sum17 = '0;
    case (op.func)
      FN_ADD, FN_ADC: begin
        c = (op.func == FN_ADC) ? cin : 1'b0;
        sum9 = {1'b0, a} + {1'b0, v} + {8'd0, c};
        nib = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, c};
        r8 = sum9[7:0];
        nf = '0;
        nf[FLAG_Z] = (r8 == 8'h00);
        nf[FLAG_H] = nib[4];
        nf[FLAG_C] = sum9[8];
      end
      FN_SUB, FN_SBC, FN_CP: begin
        c = (op.func == FN_SBC) ? cin : 1'b0;
        r8 = a - v - {7'd0, c};
        nf = '0;
        nf[FLAG_Z] = (r8 == 8'h00);
        nf[FLAG_N] = 1'b1;
        nf[FLAG_H] = ({1'b0, a[3:0]} < ({1'b0, v[3:0]} + {4'd0, c}));
        nf[FLAG_C] = ({1'b0, a} < ({1'b0, v} + {8'd0, c}));
        if (op.func == FN_CP) begin
          r8 = 8'h00;
          wr = 1'b0;
        end
      end
      FN_DAA: begin
        dec_sub = f[FLAG_N];
        dec_c = 1'b0;
        corr = 8'h00;
        if (f[FLAG_H] || (!dec_sub && a[3:0] > DAA_DIGIT)) corr = DAA_LO;
        if (f[FLAG_C] || (!dec_sub && a > DAA_LIMIT)) begin
          corr = corr | DAA_HI;
          dec_c = 1'b1;
        end
        r8 = dec_sub ? (a - corr) : (a + corr);
        nf = '0;
        nf[FLAG_Z] = (r8 == 8'h00);
        nf[FLAG_N] = dec_sub;
        nf[FLAG_C] = dec_c;
      end
      FN_RLCA: begin r8 = {a[6:0], a[7]}; nf = '0; nf[FLAG_C] = a[7]; end
      FN_RLA:  begin r8 = {a[6:0], cin};  nf = '0; nf[FLAG_C] = a[7]; end
      FN_RRCA: begin r8 = {a[0], a[7:1]}; nf = '0; nf[FLAG_C] = a[0]; end
      FN_RRA:  begin r8 = {cin, a[7:1]};  nf = '0; nf[FLAG_C] = a[0]; end
      FN_RLC:  begin r8 = {v[6:0], v[7]}; nf = '0; nf[FLAG_C] = v[7]; end
      FN_RRC:  begin r8 = {v[0], v[7:1]}; nf = '0; nf[FLAG_C] = v[0]; end
      FN_RL:   begin r8 = {v[6:0], cin};  nf = '0; nf[FLAG_C] = v[7]; end
      FN_RR:   begin r8 = {cin, v[7:1]};  nf = '0; nf[FLAG_C] = v[0]; end
      FN_SLA:  begin r8 = {v[6:0], 1'b0}; nf = '0; nf[FLAG_C] = v[7]; end
      FN_SRA:  begin r8 = {v[7], v[7:1]}; nf = '0; nf[FLAG_C] = v[0]; end
      FN_SRL:  begin r8 = {1'b0, v[7:1]}; nf = '0; nf[FLAG_C] = v[0]; end
      FN_SWAP: begin r8 = {v[3:0], v[7:4]}; nf = '0; end
      FN_BIT: begin
        nf = '0;
        nf[FLAG_Z] = ~v[op.bit_index];
        nf[FLAG_H] = 1'b1;
        nf[FLAG_C] = f[FLAG_C];
        wr = 1'b0;
      end
      FN_RES: r8 = v & ~(8'd1 << op.bit_index);
      FN_SET: r8 = v | (8'd1 << op.bit_index);
      FN_ADD16: begin
        wide = 1'b1;
        sum17 = {1'b0, op.pair_value} + {1'b0, op.wide_operand};
        low13 = {1'b0, op.pair_value[11:0]} + {1'b0, op.wide_operand[11:0]};
        nf = '0;
        nf[FLAG_Z] = f[FLAG_Z];
        nf[FLAG_H] = low13[12];
        nf[FLAG_C] = sum17[16];
      end
      default: wr = 1'b0;
    endcase
    // The shift and rotate group sets Z from the new value; the accumulator
    // rotates above leave it clear.
    if (op.func inside {FN_RLC, FN_RRC, FN_RL, FN_RR, FN_SLA, FN_SRA, FN_SRL, FN_SWAP})
      nf[FLAG_Z] = (r8 == 8'h00);
    res.result = wide ? sum17[15:0] : {8'h00, r8};
    res.flags = nf;
    res.writes_result = wr;
    return res;
  endfunction

  always @(posedge clk) begin
    alu_op_t  op;
    alu_res_t want;
    if (rst_n) begin
      if (start && !busy) begin
        op = '{in_func, in_acc, in_operand, in_bit_index, in_flags_in,
               in_pair_value, in_wide_operand};
        results_due.push_back(alu_predict(op));
      end
      if (out_valid) begin
        if (results_due.size() == 0) begin
          $error("unexpected result: result=%h flags=%b writes=%b",
                 out_result, out_flags_out, out_writes_result);
          fail_count++;
        end else begin
          want = results_due.pop_front();
          if (out_result !== want.result) begin
            $error("result: expected %h, actual %h", want.result, out_result);
            fail_count++;
          end
          if (out_flags_out !== want.flags) begin
            $error("flags_out: expected %b, actual %b", want.flags, out_flags_out);
            fail_count++;
          end
          if (out_writes_result !== want.writes_result) begin
            $error("writes_result: expected %b, actual %b",
                   want.writes_result, out_writes_result);
            fail_count++;
          end
        end
      end
    end
    pending = results_due.size();
  end

endmodule

/* tb/testbench.sv */
// Top of the 8-bit ALU testbench: clock, reset, stimulus and the final verdict.
module testbench;
  import cpu8alu_pkg::*;

  // Stimulus size and run limits. The slowest correct run (every transaction
  // after the longest idle gap, plus the pipeline) stays well under
  // CYCLE_LIMIT, so the limit leaves a wide margin.
  localparam int unsigned RANDOM_OPS   = 850;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  // Codes the ALU does not define; they must produce no write and pass flags.
  localparam logic [4:0] FN_SPARE_FIRST = 5'd22;
  localparam logic [4:0] FN_SPARE_LAST  = 5'd31;

  // Flag masks for the directed transactions.
  localparam logic [3:0] NO_FLAGS  = 4'h0;
  localparam logic [3:0] ALL_FLAGS = 4'hF;
  localparam logic [3:0] F_Z       = 4'b1 << FLAG_Z;
  localparam logic [3:0] F_N       = 4'b1 << FLAG_N;
  localparam logic [3:0] F_H       = 4'b1 << FLAG_H;
  localparam logic [3:0] F_C       = 4'b1 << FLAG_C;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [4:0]  in_func = '0;
  logic [7:0]  in_acc = '0;
  logic [7:0]  in_operand = '0;
  logic [2:0]  in_bit_index = '0;
  logic [3:0]  in_flags_in = '0;
  logic [15:0] in_pair_value = '0;
  logic [15:0] in_wide_operand = '0;
  logic        out_valid;
  logic [15:0] out_result;
  logic [3:0]  out_flags_out;
  logic        out_writes_result;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;

  // When set, transactions go in back to back so the pipeline runs full.
  bit no_idle = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cpu8_alu_with_bit_ops dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_func           (in_func),
    .in_acc            (in_acc),
    .in_operand        (in_operand),
    .in_bit_index      (in_bit_index),
    .in_flags_in       (in_flags_in),
    .in_pair_value     (in_pair_value),
    .in_wide_operand   (in_wide_operand),
    .out_valid         (out_valid),
    .out_result        (out_result),
    .out_flags_out     (out_flags_out),
    .out_writes_result (out_writes_result)
  );

  // The checker sits beside the ALU, watches both sides and counts mismatches.
  alu_checker u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_func           (in_func),
    .in_acc            (in_acc),
    .in_operand        (in_operand),
    .in_bit_index      (in_bit_index),
    .in_flags_in       (in_flags_in),
    .in_pair_value     (in_pair_value),
    .in_wide_operand   (in_wide_operand),
    .out_valid         (out_valid),
    .out_result        (out_result),
    .out_flags_out     (out_flags_out),
    .out_writes_result (out_writes_result),
    .fail_count        (fail_count),
    .pending           (pending)
  );

  // A hung pipeline must not stall the run forever.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** cpu8_alu_with_bit_ops: FAILED **");
      $finish;
    end
  end

  // Idle gaps before a transaction: half the time none, mostly a few cycles,
  // now and then a long pause so gaps land on every pipeline stage.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 25);
  endfunction

  // Bytes lean toward the all-zero and all-one corners, where carries,
  // borrows and the zero flag change.
  function automatic logic [7:0] corner_byte();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 12) return 8'h00;
    if (roll < 24) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [15:0] corner_word();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return 16'h0000;
    if (roll < 20) return 16'hFFFF;
    if (roll < 30) return 16'h0FFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  // Mostly defined operations with random operands; about one in twenty
  // transactions uses an undefined code as noise.
  function automatic alu_op_t random_op();
    alu_op_t op;
    if ($urandom_range(0, 19) == 0)
      op.func = 5'($urandom_range(FN_SPARE_FIRST, FN_SPARE_LAST));
    else
      op.func = 5'($urandom_range(FN_ADD, FN_ADD16));
    op.acc          = corner_byte();
    op.operand      = corner_byte();
    op.bit_index    = 3'($urandom_range(0, 7));
    op.flags        = 4'($urandom_range(0, 15));
    op.pair_value   = corner_word();
    op.wide_operand = corner_word();
    return op;
  endfunction

  // Presents one transaction after an optional idle gap and returns once the
  // ALU has taken it. Start stays high into the next transaction when there
  // is no gap, so it is never lowered and raised within one time step.
  task automatic issue_op(input alu_op_t op);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    in_func         <= op.func;
    in_acc          <= op.acc;
    in_operand      <= op.operand;
    in_bit_index    <= op.bit_index;
    in_flags_in     <= op.flags;
    in_pair_value   <= op.pair_value;
    in_wide_operand <= op.wide_operand;
    do @(posedge clk); while (busy);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed transactions: every operation at least once, the field extremes, and the
    // flag corner cases. Fields: func, acc, operand, bit, flags, pair, wide.
    // Add wraps to zero with both carries; add with carry gets a half carry
    // only from the incoming carry.
    issue_op('{FN_ADD,  8'hFF, 8'h01, 3'd0, NO_FLAGS,  16'h0000, 16'h0000});
    issue_op('{FN_ADC,  8'h0F, 8'h00, 3'd0, F_C,       16'h0000, 16'h0000});
    // Subtract borrows through both nibbles; subtract with borrow lands on zero.
    issue_op('{FN_SUB,  8'h00, 8'h01, 3'd0, NO_FLAGS,  16'h0000, 16'h0000});
    issue_op('{FN_SBC,  8'h10, 8'h0F, 3'd0, F_C,       16'h0000, 16'h0000});
    // Compare of equal values sets zero but writes nothing.
    issue_op('{FN_CP,   8'h3C, 8'h3C, 3'd0, NO_FLAGS,  16'h0000, 16'h0000});
    // Decimal adjust after an add that overflowed both digits, then after
    // subtracts with half borrow and with borrow.
    issue_op('{FN_DAA,  8'h9A, 8'h00, 3'd0, NO_FLAGS,  16'h0000, 16'h0000});
    issue_op('{FN_DAA,  8'h0F, 8'h00, 3'd0, F_N | F_H, 16'h0000, 16'h0000});
    issue_op('{FN_DAA,  8'h00, 8'h00, 3'd0, F_N | F_C, 16'h0000, 16'h0000});
    // Accumulator rotates always clear zero, even for a zero result.
    issue_op('{FN_RLCA, 8'h80, 8'h00, 3'd0, F_Z,       16'h0000, 16'h0000});
    issue_op('{FN_RLA,  8'h80, 8'h00, 3'd0, F_C,       16'h0000, 16'h0000});
    issue_op('{FN_RRCA, 8'h01, 8'h00, 3'd0, NO_FLAGS,  16'h0000, 16'h0000});
    issue_op('{FN_RRA,  8'h01, 8'h00, 3'd0, NO_FLAGS,  16'h0000, 16'h0000});
    // Prefixed rotates and shifts that push the low or top bit out, and a swap of zero.
    issue_op('{FN_RLC,  8'h00, 8'h80, 3'd0, NO_FLAGS,  16'h0000, 16'h0000});
    issue_op('{FN_RRC,  8'h00, 8'h01, 3'd0, NO_FLAGS,  16'h0000, 16'h0000});
    issue_op('{FN_RL,   8'h00, 8'h80, 3'd0, NO_FLAGS,  16'h0000, 16'h0000});
    issue_op('{FN_RR,   8'h00, 8'h01, 3'd0, ALL_FLAGS, 16'h0000, 16'h0000});
    issue_op('{FN_SLA,  8'h00, 8'h80, 3'd0, NO_FLAGS,  16'h0000, 16'h0000});
    issue_op('{FN_SRA,  8'h00, 8'h81, 3'd0, NO_FLAGS,  16'h0000, 16'h0000});
    issue_op('{FN_SWAP, 8'h00, 8'h00, 3'd0, ALL_FLAGS, 16'h0000, 16'h0000});
    issue_op('{FN_SRL,  8'h00, 8'h01, 3'd0, NO_FLAGS,  16'h0000, 16'h0000});
    // Bit test of a clear top bit, reset of bit zero, set of the top bit.
    issue_op('{FN_BIT,  8'h00, 8'h7F, 3'd7, ALL_FLAGS, 16'h0000, 16'h0000});
    issue_op('{FN_RES,  8'hFF, 8'hFF, 3'd0, ALL_FLAGS, 16'h0000, 16'h0000});
    issue_op('{FN_SET,  8'h00, 8'h00, 3'd7, NO_FLAGS,  16'h0000, 16'h0000});
    // Pair add: full carry out of the top, then only the carry out of bit 11
    // with the zero flag passing through.
    issue_op('{FN_ADD16, 8'h00, 8'h00, 3'd0, NO_FLAGS, 16'hFFFF, 16'h0001});
    issue_op('{FN_ADD16, 8'h00, 8'h00, 3'd0, F_Z,      16'h0FFF, 16'h0001});
    // An undefined code at the top of the range.
    issue_op('{FN_SPARE_LAST, 8'hFF, 8'hFF, 3'd7, ALL_FLAGS, 16'hFFFF, 16'hFFFF});

    // Random transactions, with a stretch of back-to-back traffic every
    // couple of hundred.
    for (int unsigned i = 0; i < RANDOM_OPS; i++) begin
      no_idle = (i % 200) < 40;
      issue_op(random_op());
    end
    start <= 1'b0;

    // Outputs and the checker settle on the rising edge, so sample at the
    // falling edge until every expected result has come back.
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("** cpu8_alu_with_bit_ops: PASSED **");
    end else begin
      $display("** cpu8_alu_with_bit_ops: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
src/cpu8alu_pkg.sv
src/cpu8alu_core.sv
src/cpu8alu_with_bit_ops.sv
tb/alu_checker.sv
tb/testbench.sv
